[design/assert_macros.svh]
// Assertion macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define I2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define I2R_NEVER(lbl, cond, msg) \
  `I2R_ASSERT(lbl, !(cond), msg)

`endif

[design/i2r_pkg.sv]
package i2r_pkg;

  localparam int unsigned DEF_PANEL_WIDTH = 16;
  localparam int unsigned DEF_COORD_BITS  = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ROW_W      = 24;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned VC_W       = 5;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned EXT_W      = 16;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ORIENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SD      = 3'd6;

  localparam logic [1:0] DIV_ROW_LO = 2'd0;
  localparam logic [1:0] DIV_ROW_HI = 2'd1;
  localparam logic [1:0] DIV_COL_LO = 2'd2;
  localparam logic [1:0] DIV_COL_HI = 2'd3;

  typedef enum logic [2:0] {
    PH_VX, PH_VK, PH_HY, PH_HK, PH_BH, PH_IW, PH_IC
  } phase_e;

  typedef struct packed {
    logic       load_begin;
    logic       div_start;
    logic       div_store;
    logic [1:0] div_idx;
    logic       row_init;
    logic       ph_en;
    phase_e     ph;
    logic       out_load;
    logic       out_zero;
    logic       row_adv;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic emit_ok;
    logic elem_valid;
    logic last_elem;
    logic out_free;
  } stat_t;

endpackage

[design/i2r_div.sv]
module i2r_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [i2r_pkg::ROW_W-1:0]   dividend_i,
  input  logic [i2r_pkg::EXT_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [i2r_pkg::ROW_W-1:0]   quot_o,
  output logic [i2r_pkg::EXT_W-1:0]   rem_o
);

  localparam int unsigned CW = $clog2(i2r_pkg::ROW_W + 1);

  logic [i2r_pkg::EXT_W:0]   rem_q;
  logic [i2r_pkg::ROW_W-1:0] quo_q;
  logic [CW-1:0]             cnt_q;
  logic                      busy_q, done_q;
  logic [i2r_pkg::EXT_W:0]   shifted;
  logic                      fits;

  assign shifted = {rem_q[i2r_pkg::EXT_W-1:0], quo_q[i2r_pkg::ROW_W-1]};
  assign fits    = shifted >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(i2r_pkg::ROW_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? shifted - {1'b0, divisor_i} : shifted;
      quo_q <= {quo_q[i2r_pkg::ROW_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[i2r_pkg::EXT_W-1:0];

endmodule

[design/i2r_ctrl.sv]
module i2r_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           opcode_i,
  output logic           in_stall_o,
  input  i2r_pkg::stat_t stat_i,
  output i2r_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV_GO, S_DIV_WAIT, S_SEL, S_CALC, S_EMIT, S_ZERO, S_FIN
  } state_e;

  state_e          state_q;
  logic [1:0]      idx_q;
  i2r_pkg::phase_e ph_q;
  logic            accept;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && state_q == S_IDLE;

  always_comb begin
    cmd_o            = '0;
    cmd_o.div_idx    = idx_q;
    cmd_o.ph         = ph_q;
    cmd_o.load_begin = accept && opcode_i == i2r_pkg::OP_BEGIN;
    cmd_o.row_init   = accept && opcode_i == i2r_pkg::OP_EMIT && stat_i.emit_ok;
    cmd_o.div_start  = state_q == S_DIV_GO;
    cmd_o.div_store  = state_q == S_DIV_WAIT && stat_i.div_done;
    cmd_o.ph_en      = state_q == S_CALC;
    cmd_o.out_load   = (state_q == S_EMIT || state_q == S_ZERO) && stat_i.out_free;
    cmd_o.out_zero   = state_q == S_ZERO;
    cmd_o.row_adv    = state_q == S_FIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= i2r_pkg::DIV_ROW_LO;
      ph_q    <= i2r_pkg::PH_VX;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (opcode_i == i2r_pkg::OP_BEGIN) begin
              idx_q   <= i2r_pkg::DIV_ROW_LO;
              state_q <= S_DIV_GO;
            end else if (stat_i.emit_ok) begin
              state_q <= S_SEL;
            end
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (stat_i.div_done) begin
            if (idx_q == i2r_pkg::DIV_COL_HI) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_DIV_GO;
            end
          end
        end
        S_SEL: begin
          ph_q    <= i2r_pkg::PH_VX;
          state_q <= stat_i.elem_valid ? S_CALC : S_ZERO;
        end
        S_CALC: begin
          case (ph_q)
            i2r_pkg::PH_VX: ph_q <= i2r_pkg::PH_VK;
            i2r_pkg::PH_VK: ph_q <= i2r_pkg::PH_HY;
            i2r_pkg::PH_HY: ph_q <= i2r_pkg::PH_HK;
            i2r_pkg::PH_HK: ph_q <= i2r_pkg::PH_BH;
            i2r_pkg::PH_BH: ph_q <= i2r_pkg::PH_IW;
            i2r_pkg::PH_IW: ph_q <= i2r_pkg::PH_IC;
            default:        state_q <= S_EMIT;
          endcase
        end
        S_EMIT, S_ZERO: begin
          if (stat_i.out_free) begin
            state_q <= stat_i.last_elem ? S_FIN : S_SEL;
          end
        end
        S_FIN:   state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[design/i2r_dp.sv]
module i2r_dp #(
  parameter int unsigned PANEL_WIDTH = i2r_pkg::DEF_PANEL_WIDTH,
  parameter int unsigned COORD_BITS  = i2r_pkg::DEF_COORD_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [i2r_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [i2r_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [i2r_pkg::ROW_W-1:0]        row_start_i,
  input  logic [i2r_pkg::ROW_W-1:0]        col_start_i,
  input  logic [i2r_pkg::CNT_W-1:0]        row_count_i,
  input  logic [i2r_pkg::VC_W-1:0]         valid_cols_i,
  input  i2r_pkg::cmd_t                    cmd_i,
  output i2r_pkg::stat_t                   stat_o,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [i2r_pkg::ADDR_W-1:0]       source_address_o,
  output logic                             zero_fill_o,
  output logic                             last_in_row_o,
  output logic                             panel_done_o
);

  localparam int unsigned CW = $clog2(PANEL_WIDTH + 1);
  localparam int unsigned EW = i2r_pkg::EXT_W;
  localparam int unsigned AW = i2r_pkg::ADDR_W;

  logic          orient_q;
  logic [31:0]   in_size_q, out_size_q, kern_q, sd_q;
  logic [15:0]   chan_q, pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q   <= 1'b0;
      in_size_q  <= '0;
      chan_q     <= 16'd1;
      out_size_q <= '0;
      kern_q     <= '0;
      pad_q      <= '0;
      sd_q       <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        i2r_pkg::REG_ORIENT:  orient_q   <= cfg_data_i[0];
        i2r_pkg::REG_IN_SIZE: in_size_q  <= cfg_data_i;
        i2r_pkg::REG_CHAN:    chan_q     <= cfg_data_i[15:0];
        i2r_pkg::REG_OUT:     out_size_q <= cfg_data_i;
        i2r_pkg::REG_KERNEL:  kern_q     <= cfg_data_i;
        i2r_pkg::REG_PAD:     pad_q      <= cfg_data_i[15:0];
        i2r_pkg::REG_SD:      sd_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [EW-1:0] kw, kh, ow, oh, rfe, rme, cfe, cme;
  assign kw  = kern_q[15:0] == '0 ? EW'(1) : kern_q[15:0];
  assign kh  = kern_q[31:16] == '0 ? EW'(1) : kern_q[31:16];
  assign ow  = out_size_q[15:0] == '0 ? EW'(1) : out_size_q[15:0];
  assign oh  = out_size_q[31:16] == '0 ? EW'(1) : out_size_q[31:16];
  assign rfe = orient_q ? ow : kw;
  assign rme = orient_q ? oh : kh;
  assign cfe = orient_q ? kw : ow;
  assign cme = orient_q ? kh : oh;

  logic [i2r_pkg::ROW_W-1:0] row_start_q, col_start_q, tmp_q;
  logic [EW-1:0]             row_fast_q, row_mid_q, col_fast_start_q, col_mid_start_q;
  logic [COORD_BITS-1:0]     row_slow_q, col_slow_start_q;
  logic [i2r_pkg::CNT_W-1:0] rows_done_q, rows_total_q;
  logic [CW-1:0]             valid_count_q;

  logic [i2r_pkg::ROW_W-1:0] div_a, div_q;
  logic [EW-1:0]             div_b, div_r;
  logic                      div_done;

  always_comb begin
    case (cmd_i.div_idx)
      i2r_pkg::DIV_ROW_LO: begin div_a = row_start_q; div_b = rfe; end
      i2r_pkg::DIV_ROW_HI: begin div_a = tmp_q;       div_b = rme; end
      i2r_pkg::DIV_COL_LO: begin div_a = col_start_q; div_b = cfe; end
      default:             begin div_a = tmp_q;       div_b = cme; end
    endcase
  end

  i2r_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  logic [EW-1:0]         cf_q, cm_q;
  logic [COORD_BITS-1:0] cs_q;
  logic [CW-1:0]         j_q;
  logic [AW-1:0]         acc_q, ix_q, iy_q;
  logic                  inb_q;

  logic [EW-1:0]         x, y, kx, ky;
  logic [COORD_BITS-1:0] cb, cc;
  always_comb begin
    if (orient_q) begin
      y = row_fast_q; x = row_mid_q; cb = row_slow_q;
      ky = cf_q; kx = cm_q; cc = cs_q;
    end else begin
      ky = row_fast_q; kx = row_mid_q; cc = row_slow_q;
      y = cf_q; x = cm_q; cb = cs_q;
    end
  end

  logic [AW-1:0]   mul_a, mul_b, prod;
  logic [2*AW-1:0] prod_full;
  always_comb begin
    case (cmd_i.ph)
      i2r_pkg::PH_VX: begin mul_a = AW'(sd_q[31:24]); mul_b = AW'(x); end
      i2r_pkg::PH_VK: begin mul_a = AW'(sd_q[15:8]);  mul_b = AW'(kx); end
      i2r_pkg::PH_HY: begin mul_a = AW'(sd_q[23:16]); mul_b = AW'(y); end
      i2r_pkg::PH_HK: begin mul_a = AW'(sd_q[7:0]);   mul_b = AW'(ky); end
      i2r_pkg::PH_BH: begin mul_a = AW'(cb);          mul_b = AW'(in_size_q[31:16]); end
      i2r_pkg::PH_IW: begin mul_a = acc_q + ix_q;     mul_b = AW'(in_size_q[15:0]); end
      default:        begin mul_a = acc_q + iy_q;     mul_b = AW'(chan_q); end
    endcase
  end
  assign prod_full = mul_a * mul_b;
  assign prod      = prod_full[AW-1:0];

  logic [EW:0] cf_inc, cm_inc, rf_inc, rm_inc;
  assign cf_inc = {1'b0, cf_q} + 1'b1;
  assign cm_inc = {1'b0, cm_q} + 1'b1;
  assign rf_inc = {1'b0, row_fast_q} + 1'b1;
  assign rm_inc = {1'b0, row_mid_q} + 1'b1;

  logic out_valid_q, zf_q, last_q, done_q;
  logic [AW-1:0] addr_q;
  logic [i2r_pkg::CNT_W:0] done_inc;
  assign done_inc = {1'b0, rows_done_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_fast_q       <= '0;
      row_mid_q        <= '0;
      row_slow_q       <= '0;
      col_fast_start_q <= '0;
      col_mid_start_q  <= '0;
      col_slow_start_q <= '0;
      rows_done_q      <= '0;
      rows_total_q     <= '0;
      valid_count_q    <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cmd_i.load_begin) begin
        rows_total_q  <= row_count_i;
        rows_done_q   <= '0;
        valid_count_q <= (32'(valid_cols_i) > 32'(PANEL_WIDTH)) ? CW'(PANEL_WIDTH)
                                                                 : CW'(valid_cols_i);
      end
      if (cmd_i.div_store) begin
        case (cmd_i.div_idx)
          i2r_pkg::DIV_ROW_LO: row_fast_q <= div_r;
          i2r_pkg::DIV_ROW_HI: begin
            row_mid_q  <= div_r;
            row_slow_q <= div_q[COORD_BITS-1:0];
          end
          i2r_pkg::DIV_COL_LO: col_fast_start_q <= div_r;
          default: begin
            col_mid_start_q  <= div_r;
            col_slow_start_q <= div_q[COORD_BITS-1:0];
          end
        endcase
      end
      if (cmd_i.row_adv) begin
        rows_done_q <= rows_done_q + 1'b1;
        if (rf_inc >= {1'b0, rfe}) begin
          row_fast_q <= '0;
          if (rm_inc >= {1'b0, rme}) begin
            row_mid_q  <= '0;
            row_slow_q <= row_slow_q + 1'b1;
          end else begin
            row_mid_q <= rm_inc[EW-1:0];
          end
        end else begin
          row_fast_q <= rf_inc[EW-1:0];
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_begin) begin
      row_start_q <= row_start_i;
      col_start_q <= col_start_i;
    end
    if (cmd_i.div_store) begin
      tmp_q <= div_q;
    end
    if (cmd_i.row_init) begin
      cf_q <= col_fast_start_q;
      cm_q <= col_mid_start_q;
      cs_q <= col_slow_start_q;
      j_q  <= '0;
    end
    if (cmd_i.ph_en) begin
      case (cmd_i.ph)
        i2r_pkg::PH_VK: ix_q <= acc_q + prod - AW'(pad_q[15:8]);
        i2r_pkg::PH_HK: iy_q <= acc_q + prod - AW'(pad_q[7:0]);
        i2r_pkg::PH_BH: begin
          acc_q <= prod;
          inb_q <= !ix_q[AW-1] && ix_q < AW'(in_size_q[31:16])
                && !iy_q[AW-1] && iy_q < AW'(in_size_q[15:0]);
        end
        default: acc_q <= prod;
      endcase
    end
    if (cmd_i.out_load) begin
      j_q    <= j_q + 1'b1;
      addr_q <= (!cmd_i.out_zero && inb_q) ? acc_q + AW'(cc) : '0;
      zf_q   <= cmd_i.out_zero || !inb_q;
      last_q <= j_q == CW'(PANEL_WIDTH - 1);
      done_q <= done_inc == {1'b0, rows_total_q};
      if (!cmd_i.out_zero) begin
        if (cf_inc >= {1'b0, cfe}) begin
          cf_q <= '0;
          if (cm_inc >= {1'b0, cme}) begin
            cm_q <= '0;
            cs_q <= cs_q + 1'b1;
          end else begin
            cm_q <= cm_inc[EW-1:0];
          end
        end else begin
          cf_q <= cf_inc[EW-1:0];
        end
      end
    end
  end

  assign stat_o.div_done   = div_done;
  assign stat_o.emit_ok    = rows_done_q < rows_total_q;
  assign stat_o.elem_valid = j_q < valid_count_q;
  assign stat_o.last_elem  = j_q == CW'(PANEL_WIDTH - 1);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign source_address_o = addr_q;
  assign zero_fill_o      = zf_q;
  assign last_in_row_o    = last_q;
  assign panel_done_o     = done_q;

endmodule

[design/im2row_panel_address_generator.sv]
// Generates NHWC source addresses for packing one im2row panel. A begin word's
// start row and start column are split into odometer counters by four 24-step
// divisions in one shared radix-2 divider, and no word is accepted meanwhile.
// An emit word yields PANEL_WIDTH result words, and no word is accepted until
// the row is done; the address of each column within the valid count is built
// by seven passes through one shared 32 by 32 multiplier, while each
// zero-filled column past the valid count skips them. Any output stall holds
// the row back. An emit past the panel's last row is taken and yields nothing.
// The configuration port is always ready.
module im2row_panel_address_generator #(
  parameter int unsigned PANEL_WIDTH = i2r_pkg::DEF_PANEL_WIDTH,
  parameter int unsigned COORD_BITS  = i2r_pkg::DEF_COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [i2r_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [i2r_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [i2r_pkg::ROW_W-1:0]      row_start_i,
  input  logic [i2r_pkg::ROW_W-1:0]      col_start_i,
  input  logic [i2r_pkg::CNT_W-1:0]      row_count_i,
  input  logic [i2r_pkg::VC_W-1:0]       valid_cols_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [i2r_pkg::ADDR_W-1:0]     source_address_o,
  output logic                           zero_fill_o,
  output logic                           last_in_row_o,
  output logic                           panel_done_o
);

  i2r_pkg::cmd_t  cmd;
  i2r_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  i2r_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  i2r_dp #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .row_start_i      (row_start_i),
    .col_start_i      (col_start_i),
    .row_count_i      (row_count_i),
    .valid_cols_i     (valid_cols_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .source_address_o (source_address_o),
    .zero_fill_o      (zero_fill_o),
    .last_in_row_o    (last_in_row_o),
    .panel_done_o     (panel_done_o)
  );

endmodule

[design/i2r_checker.sv]
`include "assert_macros.svh"

module i2r_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       opcode_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [i2r_pkg::ADDR_W-1:0] source_address_o,
  input logic                       zero_fill_o
);

  `I2R_NEVER(a_zero_addr, out_valid_o && zero_fill_o && source_address_o != '0, "zero-filled word carries an address")
  `I2R_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(source_address_o), "stalled output word changed")
  `I2R_ASSERT(a_begin_busy, in_valid_i && !in_stall_o && opcode_i == i2r_pkg::OP_BEGIN |=> in_stall_o, "begin word did not start the split")

endmodule

bind im2row_panel_address_generator i2r_checker u_i2r_checker (.*);
